FILE: hdl/frb_pkg.sv
// shared constants, types and codes for the fragment reassembly buffer
// no dependencies
`timescale 1ns / 1ps

package frb_pkg;

	// block configuration
	localparam int HEADER_BYTES = 8;
	localparam int MAX_DATA     = 256;
	localparam int BUF_CAP      = 4096;

	// port field widths
	localparam int ACT_W   = 3;
	localparam int SEQ_W   = 16;
	localparam int PLEN_W  = 16;
	localparam int POS_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int RADDR_W = 12;
	localparam int TLEN_W  = 13;

	// derived internal widths
	localparam int ADDR_W = $clog2(BUF_CAP);
	localparam int RUN_W  = $clog2(BUF_CAP + 1);
	localparam int DL_W   = $clog2(MAX_DATA + 1);
	localparam int OFF_W  = $clog2((2 ** SEQ_W - 1) * MAX_DATA);

	localparam logic [PLEN_W-1:0] HDR_PLEN  = PLEN_W'(HEADER_BYTES);
	localparam logic [PLEN_W-1:0] MAXD_PLEN = PLEN_W'(MAX_DATA);
	localparam logic [POS_W-1:0]  HDR_POS   = POS_W'(HEADER_BYTES);

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 3'd0,
		ACT_HEADER = 3'd1,
		ACT_BYTE   = 3'd2,
		ACT_FINISH = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_RESP,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic take;
		logic sweep;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} dp_stat_t;

endpackage

FILE: hdl/frb_ctrl.sv
// controller: sequences item execution, store clearing and result handoff
// depends on frb_pkg
`timescale 1ns / 1ps

module frb_ctrl import frb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ACT_W-1:0] action,
	output logic             out_valid,
	input  logic             out_ready,
	output ctrl_cmd_t        cmd,
	input  dp_stat_t         stat
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// ready is high throughout idle, so valid alone marks the beat
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid) begin
					state_nxt = (action == ACT_CLEAR) ? ST_CLEAR : ST_RESP;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				// hold the result until the output register is free
				if (out_free) begin
					cmd.load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

endmodule

FILE: hdl/frb_dp.sv
// datapath: reassembly store, fragment bookkeeping and result register
// depends on frb_pkg
`timescale 1ns / 1ps

module frb_dp import frb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output dp_stat_t           stat,
	input  logic [ACT_W-1:0]   action,
	input  logic [SEQ_W-1:0]   sequence_number,
	input  logic [PLEN_W-1:0]  payload_length,
	input  logic [POS_W-1:0]   byte_position,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [RADDR_W-1:0] read_address,
	output logic [BYTE_W-1:0]  read_data,
	output logic [TLEN_W-1:0]  total_length,
	output logic               fragment_accepted
);

	logic [BYTE_W-1:0] mem [BUF_CAP];

	logic [RUN_W-1:0]  run_q;
	logic [RUN_W-1:0]  off_q;
	logic [DL_W-1:0]   dl_q;
	logic              ok_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [BYTE_W-1:0] rd_q;
	logic              rd_ok_q;

	logic [BYTE_W-1:0] read_data_q;
	logic [TLEN_W-1:0] total_length_q;
	logic              fragment_accepted_q;

	logic              do_clear, do_hdr, do_byte, do_fin, do_read;
	logic [PLEN_W-1:0] dl_raw;
	logic [DL_W-1:0]   dl_c;
	logic [SEQ_W-1:0]  seq_m1;
	logic [OFF_W-1:0]  off_full;
	logic [OFF_W:0]    end_full;
	logic              hdr_ok;
	logic [POS_W-1:0]  rel;
	logic [RUN_W:0]    baddr;
	logic              byte_we;
	logic [RUN_W-1:0]  fin_len;
	logic              raddr_ok;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [BYTE_W-1:0] wdata;

	assign do_clear = cmd.take && (action == ACT_CLEAR);
	assign do_hdr   = cmd.take && (action == ACT_HEADER);
	assign do_byte  = cmd.take && (action == ACT_BYTE);
	assign do_fin   = cmd.take && (action == ACT_FINISH);
	assign do_read  = cmd.take && (action == ACT_READ);

	assign stat.sweep_last = (clr_cnt_q == ADDR_W'(BUF_CAP - 1));

	// header: data length clamp, offset by constant multiply, bounds check
	assign dl_raw   = (payload_length > HDR_PLEN) ? payload_length - HDR_PLEN : '0;
	assign dl_c     = (dl_raw > MAXD_PLEN) ? DL_W'(MAX_DATA) : DL_W'(dl_raw);
	assign seq_m1   = sequence_number - SEQ_W'(1);
	assign off_full = OFF_W'(OFF_W'(seq_m1) * OFF_W'(MAX_DATA));
	assign end_full = {1'b0, off_full} + (OFF_W + 1)'(dl_c);
	assign hdr_ok   = (sequence_number != '0) && (end_full <= (OFF_W + 1)'(BUF_CAP));

	// payload byte: window check relative to the accepted fragment
	assign rel     = byte_position - HDR_POS;
	assign baddr   = {1'b0, off_q} + (RUN_W + 1)'(rel[DL_W-1:0]);
	assign byte_we = do_byte && ok_q && (byte_position >= HDR_POS)
		&& (rel < POS_W'(dl_q)) && (baddr < (RUN_W + 1)'(BUF_CAP));

	assign fin_len = (run_q >= RUN_W'(BUF_CAP)) ? RUN_W'(BUF_CAP - 1) : run_q;

	assign raddr_ok = (32'(read_address) < 32'(BUF_CAP));

	always_comb begin
		we    = 1'b0;
		waddr = clr_cnt_q;
		wdata = '0;
		priority if (cmd.sweep) begin
			we = 1'b1;
		end else if (byte_we) begin
			we    = 1'b1;
			waddr = ADDR_W'(baddr);
			wdata = data_byte;
		end else if (do_fin) begin
			we    = 1'b1;
			waddr = ADDR_W'(fin_len);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			rd_q <= mem[ADDR_W'(read_address)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= '0;
			off_q     <= '0;
			dl_q      <= '0;
			ok_q      <= 1'b0;
			clr_cnt_q <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (cmd.sweep) begin
				clr_cnt_q <= stat.sweep_last ? '0 : clr_cnt_q + ADDR_W'(1);
			end
			if (cmd.take) begin
				rd_ok_q <= do_read && raddr_ok;
			end
			if (do_clear) begin
				run_q <= '0;
				off_q <= '0;
				dl_q  <= '0;
				ok_q  <= 1'b0;
			end else if (do_hdr) begin
				if (hdr_ok) begin
					ok_q  <= 1'b1;
					off_q <= RUN_W'(off_full);
					dl_q  <= dl_c;
					if (end_full > (OFF_W + 1)'(run_q)) begin
						run_q <= RUN_W'(end_full);
					end
				end else begin
					ok_q  <= 1'b0;
					off_q <= '0;
					dl_q  <= '0;
				end
			end else if (do_fin) begin
				run_q <= fin_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_data_q         <= rd_ok_q ? rd_q : '0;
			total_length_q      <= TLEN_W'(run_q);
			fragment_accepted_q <= ok_q;
		end
	end

	assign read_data         = read_data_q;
	assign total_length      = total_length_q;
	assign fragment_accepted = fragment_accepted_q;

endmodule

FILE: hdl/fragment_reassembly_buffer_core.sv
// fragment reassembly buffer: clear, header, payload byte, finish and read items
// each item: accept, then result register load; no new item is taken before that load
// clear item: store swept one entry per cycle through the write port, then result load
// after reset: clearing pass over all 4096 store entries, in_ready low until done
// reset clears control state and fragment bookkeeping; depends on frb_pkg, frb_ctrl, frb_dp
`timescale 1ns / 1ps

module fragment_reassembly_buffer_core import frb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ACT_W-1:0]   action,
	input  logic [SEQ_W-1:0]   sequence_number,
	input  logic [PLEN_W-1:0]  payload_length,
	input  logic [POS_W-1:0]   byte_position,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [RADDR_W-1:0] read_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  read_data,
	output logic [TLEN_W-1:0]  total_length,
	output logic               fragment_accepted
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	frb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	frb_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.action            (action),
		.sequence_number   (sequence_number),
		.payload_length    (payload_length),
		.byte_position     (byte_position),
		.data_byte         (data_byte),
		.read_address      (read_address),
		.read_data         (read_data),
		.total_length      (total_length),
		.fragment_accepted (fragment_accepted)
	);

endmodule

FILE: hdl/frb_checker.sv
// port-level checks for the fragment reassembly buffer, bound to the top level
// depends on frb_pkg and fragment_reassembly_buffer_core
`timescale 1ns / 1ps

module frb_checker import frb_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [BYTE_W-1:0]  read_data,
	input logic [TLEN_W-1:0]  total_length,
	input logic               fragment_accepted
);

	// one item in flight: no beat right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in progress");

	// a result only appears while an item is being worked
	a_result_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result beat without an item in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(read_data)
			&& $stable(total_length) && $stable(fragment_accepted)))
		else $error("stalled result beat changed");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((BUF_CAP >= 2 ** TLEN_W) || (total_length <= TLEN_W'(BUF_CAP))))
		else $error("reassembled length beyond store capacity");

endmodule

bind fragment_reassembly_buffer_core frb_checker u_frb_checker (.*);
